// ===== rtl/lipw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipw_pkg
// Shared constants, register indexes and helpers for the intensity to
// current/pwm word core.
// ----------------------------------------------------------------------------
package lipw_pkg;

    localparam int INTENSITY_W = 16;
    localparam int PRODUCT_W   = 32;
    localparam int LEVEL_W     = 5;
    localparam int PWM_W       = 8;
    localparam int GAIN_W      = 8;
    localparam int WORD_W      = 32;
    localparam int CFG_INDEX_W = 2;

    // level division: remainder width, one cell per quotient bit
    localparam int LEVEL_DIV_W   = 28;
    localparam int LEVEL_CELLS   = 5;
    // spread division by the level
    localparam int SPREAD_DIV_W  = 5;
    localparam int SPREAD_CELLS  = 28;
    // width division
    localparam int WIDTH_DIV_W   = 20;
    localparam int WIDTH_CELLS   = 8;

    localparam logic [LEVEL_DIV_W-1:0] LEVEL_STEP = 28'd138543105;
    localparam logic [WIDTH_DIV_W-1:0] WIDTH_DIV  = 20'd541185;
    localparam logic [2:0]             LEVEL_TAG  = 3'b111;

    localparam logic [GAIN_W-1:0] RED_GAIN_RST   = 8'd255;
    localparam logic [GAIN_W-1:0] GREEN_GAIN_RST = 8'd192;
    localparam logic [GAIN_W-1:0] BLUE_GAIN_RST  = 8'd127;

    // pipeline depth from accepted transaction to result strobe
    localparam int PIPE_LATENCY = 1 + LEVEL_CELLS + SPREAD_CELLS + WIDTH_CELLS + 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RED_GAIN   = 2'd0,
        CFG_GREEN_GAIN = 2'd1,
        CFG_BLUE_GAIN  = 2'd2
    } cfg_index_t;

    // floor(v / 255), exact for v up to 65279
    function automatic logic [PWM_W-1:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== rtl/lipw_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipw_div_cell
// One restoring division step: shifts in a dividend bit, conditionally
// subtracts the divisor and shifts the quotient bit in, then registers.
// ----------------------------------------------------------------------------
module lipw_div_cell
    import lipw_pkg::*;
#(
    parameter int DW = 8,
    parameter int NW = 8,
    parameter int TW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [NW-1:0] in_quo,
    input  logic [DW-1:0] in_div,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_num,
    output logic [NW-1:0] out_quo,
    output logic [DW-1:0] out_div,
    output logic [TW-1:0] out_tag
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg,  rem_next;
    logic [NW-1:0] num_reg,  num_next;
    logic [NW-1:0] quo_reg,  quo_next;
    logic [DW-1:0] div_reg;
    logic [TW-1:0] tag_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    always_comb
    begin
        trial    = {in_rem, in_num[NW-1]};
        diff     = trial - {1'b0, in_div};
        fits     = (trial >= {1'b0, in_div});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {in_quo[NW-2:0], fits};
        num_next = {in_num[NW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        div_reg <= in_div;
        tag_reg <= in_tag;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;
    assign out_tag   = tag_reg;

endmodule

// ===== rtl/lipw_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipw_div_chain
// Row of division cells, one quotient bit per cell, one new dividend
// entering every cycle.
// ----------------------------------------------------------------------------
module lipw_div_chain
    import lipw_pkg::*;
#(
    parameter int DW = 8,
    parameter int NW = 8,
    parameter int TW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [TW-1:0] out_tag
);

    logic          vld [NW+1];
    logic [DW-1:0] rem [NW+1];
    logic [NW-1:0] num [NW+1];
    logic [NW-1:0] quo [NW+1];
    logic [DW-1:0] dvs [NW+1];
    logic [TW-1:0] tag [NW+1];

    assign vld[0] = in_valid;
    assign rem[0] = in_rem;
    assign num[0] = in_num;
    assign quo[0] = '0;
    assign dvs[0] = in_div;
    assign tag[0] = in_tag;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        lipw_div_cell #(
            .DW (DW),
            .NW (NW),
            .TW (TW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i]),
            .in_rem    (rem[i]),
            .in_num    (num[i]),
            .in_quo    (quo[i]),
            .in_div    (dvs[i]),
            .in_tag    (tag[i]),
            .out_valid (vld[i+1]),
            .out_rem   (rem[i+1]),
            .out_num   (num[i+1]),
            .out_quo   (quo[i+1]),
            .out_div   (dvs[i+1]),
            .out_tag   (tag[i+1])
        );
    end

    assign out_valid = vld[NW];
    assign out_quo   = quo[NW];
    assign out_tag   = tag[NW];

endmodule

// ===== rtl/lipw_gain_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipw_gain_stage
// Applies the colour gains to the pwm width and packs the led word.
// ----------------------------------------------------------------------------
module lipw_gain_stage
    import lipw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [PWM_W-1:0]   in_pwm,
    input  logic [LEVEL_W-1:0] in_level,
    input  logic [GAIN_W-1:0]  red_gain,
    input  logic [GAIN_W-1:0]  green_gain,
    input  logic [GAIN_W-1:0]  blue_gain,
    output logic               done,
    output logic [WORD_W-1:0]  led_word,
    output logic [LEVEL_W-1:0] current_level,
    output logic [PWM_W-1:0]   pwm_width
);

    logic               prod_valid_reg;
    logic [15:0]        red_prod_reg;
    logic [15:0]        green_prod_reg;
    logic [15:0]        blue_prod_reg;
    logic [PWM_W-1:0]   prod_pwm_reg;
    logic [LEVEL_W-1:0] prod_level_reg;

    logic               done_reg;
    logic [WORD_W-1:0]  word_reg,  word_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [PWM_W-1:0]   pwm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            done_reg       <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_prod_reg   <= 16'(in_pwm) * 16'(red_gain);
        green_prod_reg <= 16'(in_pwm) * 16'(green_gain);
        blue_prod_reg  <= 16'(in_pwm) * 16'(blue_gain);
        prod_pwm_reg   <= in_pwm;
        prod_level_reg <= in_level;
    end

    always_comb
    begin
        word_next = {div255(red_prod_reg), div255(green_prod_reg),
                     div255(blue_prod_reg), LEVEL_TAG, prod_level_reg};
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        level_reg <= prod_level_reg;
        pwm_reg   <= prod_pwm_reg;
    end

    assign done          = done_reg;
    assign led_word      = word_reg;
    assign current_level = level_reg;
    assign pwm_width     = pwm_reg;

    // level field in the word matches the level port
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (led_word[7:5] == LEVEL_TAG) && (led_word[4:0] == current_level))
        else $error("led word level field mismatch");

    // a gain never exceeds unity
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (led_word[31:24] <= pwm_width) && (led_word[23:16] <= pwm_width)
                 && (led_word[15:8] <= pwm_width))
        else $error("colour channel above pwm width");

endmodule

// ===== rtl/led_intensity_to_current_pwm_word_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_intensity_to_current_pwm_word_core
// Splits a linear intensity into a global current level and a pwm width and
// packs the gained colour channels into one led word.
// ----------------------------------------------------------------------------
// One intensity is taken every cycle (busy is always low) and its result is
// strobed on done, with led_word, current_level and pwm_width valid only in
// the cycle that done is high; results cannot be held off, so the receiver
// must take them as they come. The path runs through an input register, a
// row of 41 division cells, one quotient bit each: 5 for the current level,
// 28 for spreading the remainder over the level and 8 for the pwm width, and
// then a gain multiply register and the output register. Gains should only
// be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module led_intensity_to_current_pwm_word_core
    import lipw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [INTENSITY_W-1:0] intensity,
    output logic                   done,
    output logic [WORD_W-1:0]      led_word,
    output logic [LEVEL_W-1:0]     current_level,
    output logic [PWM_W-1:0]       pwm_width,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data
);

    logic [GAIN_W-1:0] red_gain_reg;
    logic [GAIN_W-1:0] green_gain_reg;
    logic [GAIN_W-1:0] blue_gain_reg;

    logic                 in_valid_reg;
    logic [PRODUCT_W-1:0] product_reg, product_next;

    logic                 lvl_valid;
    logic [LEVEL_W-1:0]   lvl_quo;
    logic [PRODUCT_W-1:0] lvl_product;

    logic                 spr_in_valid;
    logic [PRODUCT_W-1:0] spr_num;
    logic [LEVEL_W-1:0]   spr_level;
    logic                 spr_valid;
    logic [SPREAD_CELLS-1:0] spr_quo;
    logic [LEVEL_W-1:0]   spr_tag;

    logic                 wid_valid;
    logic [PWM_W-1:0]     wid_quo;
    logic [LEVEL_W-1:0]   wid_tag;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // colour gains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_gain_reg   <= RED_GAIN_RST;
            green_gain_reg <= GREEN_GAIN_RST;
            blue_gain_reg  <= BLUE_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RED_GAIN:   red_gain_reg   <= cfg_data;
                CFG_GREEN_GAIN: green_gain_reg <= cfg_data;
                CFG_BLUE_GAIN:  blue_gain_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // intensity * 65535
    always_comb
    begin
        product_next = {intensity, 16'd0} - {16'd0, intensity};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    // level minus one
    lipw_div_chain #(
        .DW (LEVEL_DIV_W),
        .NW (LEVEL_CELLS),
        .TW (PRODUCT_W)
    ) u_level_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_rem    ({1'b0, product_reg[PRODUCT_W-1:LEVEL_CELLS]}),
        .in_num    (product_reg[LEVEL_CELLS-1:0]),
        .in_div    (LEVEL_STEP),
        .in_tag    (product_reg),
        .out_valid (lvl_valid),
        .out_quo   (lvl_quo),
        .out_tag   (lvl_product)
    );

    always_comb
    begin
        spr_in_valid = lvl_valid;
        spr_num      = lvl_product - {{(PRODUCT_W-LEVEL_W){1'b0}}, lvl_quo};
        spr_level    = lvl_quo + 5'd1;
    end

    // spread over the level
    lipw_div_chain #(
        .DW (SPREAD_DIV_W),
        .NW (SPREAD_CELLS),
        .TW (LEVEL_W)
    ) u_spread_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (spr_in_valid),
        .in_rem    ({1'b0, spr_num[PRODUCT_W-1:SPREAD_CELLS]}),
        .in_num    (spr_num[SPREAD_CELLS-1:0]),
        .in_div    (spr_level),
        .in_tag    (spr_level),
        .out_valid (spr_valid),
        .out_quo   (spr_quo),
        .out_tag   (spr_tag)
    );

    // pwm width
    lipw_div_chain #(
        .DW (WIDTH_DIV_W),
        .NW (WIDTH_CELLS),
        .TW (LEVEL_W)
    ) u_width_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (spr_valid),
        .in_rem    (spr_quo[SPREAD_CELLS-1:WIDTH_CELLS]),
        .in_num    (spr_quo[WIDTH_CELLS-1:0]),
        .in_div    (WIDTH_DIV),
        .in_tag    (spr_tag),
        .out_valid (wid_valid),
        .out_quo   (wid_quo),
        .out_tag   (wid_tag)
    );

    lipw_gain_stage u_gain_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (wid_valid),
        .in_pwm        (wid_quo),
        .in_level      (wid_tag),
        .red_gain      (red_gain_reg),
        .green_gain    (green_gain_reg),
        .blue_gain     (blue_gain_reg),
        .done          (done),
        .led_word      (led_word),
        .current_level (current_level),
        .pwm_width     (pwm_width)
    );

    // every result has a matching accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without matching transaction");

    // level never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (current_level != 5'd0))
        else $error("current level out of range");

endmodule

// ===== bench/led_intensity_to_current_pwm_word_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_intensity_to_current_pwm_word_core_test
// Self-checking bench for the intensity to current/pwm word core. Intensities
// are sent with random gaps, gains are rewritten between drained phases, and
// every strobed led_word, current_level and pwm_width is compared with a
// prediction from the intensity and the gains in force when it was accepted.
// ----------------------------------------------------------------------------
module led_intensity_to_current_pwm_word_core_test;
    import lipw_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int BOUNDARY_SPAN = 30;

    typedef struct packed {
        logic [WORD_W-1:0]  led_word;
        logic [LEVEL_W-1:0] level;
        logic [PWM_W-1:0]   pwm;
    } led_word_t;

    class pwm_word_scoreboard;
        logic [GAIN_W-1:0] red_gain;
        logic [GAIN_W-1:0] green_gain;
        logic [GAIN_W-1:0] blue_gain;
        led_word_t         pending_words[$];
        int                errors;

        function new();
            red_gain   = RED_GAIN_RST;
            green_gain = GREEN_GAIN_RST;
            blue_gain  = BLUE_GAIN_RST;
            errors     = 0;
        endfunction

        function void write_gain(logic [CFG_INDEX_W-1:0] idx, logic [GAIN_W-1:0] v);
            case (idx)
                CFG_RED_GAIN:   red_gain = v;
                CFG_GREEN_GAIN: green_gain = v;
                CFG_BLUE_GAIN:  blue_gain = v;
                default:        ;
            endcase
        endfunction

        function led_word_t compute_led_word(logic [INTENSITY_W-1:0] x);
            logic [63:0] product;
            logic [63:0] level;
            logic [63:0] remainder;
            logic [63:0] spread;
            logic [63:0] pwm;
            logic [63:0] red;
            logic [63:0] green;
            logic [63:0] blue;
            led_word_t   w;
            product   = 64'(x) * 64'd65535;
            level     = product / 64'd138543105 + 64'd1;
            remainder = product % 64'd138543105;
            spread    = (remainder + 64'd138543104 * (level - 64'd1)) / level;
            pwm       = spread / 64'd541185;
            red       = (pwm * 64'(red_gain)) / 64'd255;
            green     = (pwm * 64'(green_gain)) / 64'd255;
            blue      = (pwm * 64'(blue_gain)) / 64'd255;
            w.level    = level[LEVEL_W-1:0];
            w.pwm      = pwm[PWM_W-1:0];
            w.led_word = {red[7:0], green[7:0], blue[7:0], LEVEL_TAG, w.level};
            return w;
        endfunction

        function void note_intensity(logic [INTENSITY_W-1:0] x);
            pending_words.push_back(compute_led_word(x));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 200)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [WORD_W-1:0] word, logic [LEVEL_W-1:0] level,
                          logic [PWM_W-1:0] pwm);
            led_word_t exp_w;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected result word %h", word));
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (word !== exp_w.led_word)
                    report($sformatf("led_word %h, expected %h", word, exp_w.led_word));
                if (level !== exp_w.level)
                    report($sformatf("current_level %0d, expected %0d", level, exp_w.level));
                if (pwm !== exp_w.pwm)
                    report($sformatf("pwm_width %0d, expected %0d", pwm, exp_w.pwm));
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [INTENSITY_W-1:0] intensity;
    logic                   done;
    logic [WORD_W-1:0]      led_word;
    logic [LEVEL_W-1:0]     current_level;
    logic [PWM_W-1:0]       pwm_width;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]      cfg_data;

    pwm_word_scoreboard sb;

    led_intensity_to_current_pwm_word_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .intensity     (intensity),
        .done          (done),
        .led_word      (led_word),
        .current_level (current_level),
        .pwm_width     (pwm_width),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // sample transactions on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (done)
                sb.check_result(led_word, current_level, pwm_width);
            if (start && !busy)
                sb.note_intensity(intensity);
            if (cfg_valid && cfg_ready)
                sb.write_gain(cfg_index, cfg_data);
        end
    end

    task automatic send_intensity(logic [INTENSITY_W-1:0] x);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        intensity <= x;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [GAIN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_gains(logic [GAIN_W-1:0] r, logic [GAIN_W-1:0] g,
                               logic [GAIN_W-1:0] b);
        drain_results();
        write_reg(CFG_RED_GAIN, r);
        write_reg(CFG_GREEN_GAIN, g);
        write_reg(CFG_BLUE_GAIN, b);
    endtask

    // mix of uniform values, level boundaries and the ends of the range
    function automatic logic [INTENSITY_W-1:0] pick_intensity();
        int k;
        int x;
        case ($urandom_range(0, 3))
            0:
            begin
                k = $urandom_range(1, BOUNDARY_SPAN);
                x = int'((64'(k) * 64'd138543105 + 64'd65534) / 64'd65535);
                x = x + int'($urandom_range(0, 6)) - 3;
                if (x > 65535)
                    x = 65535;
            end
            1:
            begin
                if ($urandom_range(0, 1) == 1)
                    x = 65535 - int'($urandom_range(0, 300));
                else
                    x = $urandom_range(0, 300);
            end
            default: x = $urandom_range(0, 65535);
        endcase
        return x[INTENSITY_W-1:0];
    endfunction

    initial
    begin
        logic [INTENSITY_W-1:0] directed_list[$];
        sb = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        intensity = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset gains, extremes and the first level boundaries
        directed_list = '{16'd0, 16'd1, 16'd2, 16'd2114, 16'd2115, 16'd4228, 16'd4229,
                          16'd4230, 16'd32767, 16'd32768, 16'h5555, 16'haaaa,
                          16'd63420, 16'd63421, 16'd65534, 16'd65535};
        foreach (directed_list[i])
            send_intensity(directed_list[i]);

        write_gains(8'd0, 8'd0, 8'd0);
        send_intensity(16'd65535);
        send_intensity(16'd2115);
        write_gains(8'd255, 8'd255, 8'd255);
        send_intensity(16'd65535);
        send_intensity(16'd0);
        send_intensity(16'd40000);
        // an unmapped index must leave the gains untouched
        drain_results();
        write_reg(CFG_UNUSED, 8'h00);
        send_intensity(16'd65535);
        send_intensity(16'd12345);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: write_gains(8'd255, 8'd192, 8'd127);
                1: write_gains(8'd0, 8'd255, 8'd1);
                2: write_gains(8'd254, 8'd0, 8'd255);
                default:
                    write_gains(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
            endcase
            if (phase == 4)
            begin
                drain_results();
                write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
            end
            for (int n = 0; n < 200; n++)
                send_intensity(pick_intensity());
        end

        drain_results();
        repeat (PIPE_LATENCY + 8) @(negedge clk);
        if (sb.errors == 0)
            $display("led_intensity_to_current_pwm_word_core_test: clean");
        else
            $display("led_intensity_to_current_pwm_word_core_test: errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("led_intensity_to_current_pwm_word_core_test: errors");
        $finish;
    end

endmodule
